// ----- design/fmmc_pkg.sv -----
// package: shared types and constants for the fan menu and mode controller
`timescale 1ns / 1ps

package fmmc_pkg;

    // event kinds carried in the opcode field
    localparam logic [1:0] OP_ENCODER = 2'd0;
    localparam logic [1:0] OP_MODE    = 2'd1;
    localparam logic [1:0] OP_SELECT  = 2'd2;
    localparam logic [1:0] OP_SENSOR  = 2'd3;

    // menu cursor entries
    localparam logic [1:0] CURSOR_BACK    = 2'd0;
    localparam logic [1:0] CURSOR_FAN_OFF = 2'd1;
    localparam logic [1:0] CURSOR_FAN_ON  = 2'd2;
    localparam logic [1:0] CURSOR_LAST    = CURSOR_FAN_ON;

    // duty levels in percent
    localparam logic [6:0] DUTY_OFF  = 7'd0;
    localparam logic [6:0] DUTY_LOW  = 7'd50;
    localparam logic [6:0] DUTY_MID  = 7'd70;
    localparam logic [6:0] DUTY_FULL = 7'd100;

    // tier thresholds, a reading strictly above the limit trips the tier
    localparam logic [7:0]  TEMP_FULL = 8'd35;
    localparam logic [7:0]  HUM_FULL  = 8'd80;
    localparam logic [11:0] GAS_FULL  = 12'd2500;
    localparam logic [7:0]  TEMP_MID  = 8'd33;
    localparam logic [7:0]  HUM_MID   = 8'd70;
    localparam logic [11:0] GAS_MID   = 12'd1800;
    localparam logic [7:0]  TEMP_LOW  = 8'd30;
    localparam logic [7:0]  HUM_LOW   = 8'd60;
    localparam logic [11:0] GAS_LOW   = 12'd1500;

    // one input event
    typedef struct packed {
        logic [1:0]  opcode;
        logic        clk_level;
        logic        dt_level;
        logic [7:0]  temperature;
        logic [7:0]  humidity;
        logic [11:0] gas_level;
    } in_item_t;

    // one result
    typedef struct packed {
        logic [6:0] duty_percent;
        logic       in_menu;
        logic [1:0] cursor_pos;
        logic       manual_mode;
        logic       manual_fan_on;
    } out_item_t;

    // controller state
    typedef struct packed {
        logic       menu_open;
        logic [1:0] cursor;
        logic       manual_flag_mode;
        logic       fan_on_flag;
        logic       prev_clk;
        logic [6:0] duty;
    } fmmc_state_t;

endpackage

// ----- design/fmmc_stream_if.sv -----
// interface: valid/ready channel carrying one payload per transaction
`timescale 1ns / 1ps

interface fmmc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/fmmc_step.sv -----
// module: next-state logic for one controller event
`timescale 1ns / 1ps

module fmmc_step
    import fmmc_pkg::*;
(
    input  in_item_t    item,
    input  fmmc_state_t cur,
    output fmmc_state_t nxt
);

    logic [6:0] tier_duty;
    logic       tier_full;
    logic       tier_mid;
    logic       tier_low;
    logic       fall_edge;

    // tiered threshold duty
    always_comb
    begin
        tier_full = (item.temperature > TEMP_FULL) || (item.humidity > HUM_FULL)
                    || (item.gas_level > GAS_FULL);
        tier_mid  = (item.temperature > TEMP_MID) || (item.humidity > HUM_MID)
                    || (item.gas_level > GAS_MID);
        tier_low  = (item.temperature > TEMP_LOW) || (item.humidity > HUM_LOW)
                    || (item.gas_level > GAS_LOW);
        if (tier_full)
        begin
            tier_duty = DUTY_FULL;
        end
        else if (tier_mid)
        begin
            tier_duty = DUTY_MID;
        end
        else if (tier_low)
        begin
            tier_duty = DUTY_LOW;
        end
        else
        begin
            tier_duty = DUTY_OFF;
        end
    end

    assign fall_edge = !item.clk_level && cur.prev_clk;

    // event dispatch
    always_comb
    begin
        nxt = cur;
        case (item.opcode)
            OP_ENCODER:
            begin
                if (fall_edge && cur.menu_open)
                begin
                    if (item.dt_level)
                    begin
                        // turn one way: step down, wrap to last entry
                        nxt.cursor = (cur.cursor == CURSOR_BACK) ? CURSOR_LAST
                                     : cur.cursor - 2'd1;
                    end
                    else
                    begin
                        nxt.cursor = (cur.cursor >= CURSOR_LAST) ? CURSOR_BACK
                                     : cur.cursor + 2'd1;
                    end
                end
                nxt.prev_clk = item.clk_level;
            end
            OP_MODE:
            begin
                if (!cur.menu_open)
                begin
                    nxt.manual_flag_mode = !cur.manual_flag_mode;
                    if (!cur.manual_flag_mode)
                    begin
                        nxt.fan_on_flag = 1'b0;
                    end
                end
            end
            OP_SELECT:
            begin
                if (!cur.menu_open)
                begin
                    nxt.menu_open = 1'b1;
                    nxt.cursor    = CURSOR_BACK;
                end
                else
                begin
                    // back, or any other cursor value, just closes the menu
                    if (cur.cursor == CURSOR_FAN_OFF)
                    begin
                        nxt.manual_flag_mode = 1'b1;
                        nxt.fan_on_flag      = 1'b0;
                        nxt.duty             = DUTY_OFF;
                    end
                    else if (cur.cursor == CURSOR_FAN_ON)
                    begin
                        nxt.manual_flag_mode = 1'b1;
                        nxt.fan_on_flag      = 1'b1;
                        nxt.duty             = DUTY_FULL;
                    end
                    nxt.menu_open = 1'b0;
                end
            end
            OP_SENSOR:
            begin
                if (!cur.menu_open && !cur.manual_flag_mode)
                begin
                    nxt.duty = tier_duty;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- design/fan_menu_mode_controller_unit.sv -----
// module: top level of the fan menu and mode controller
`timescale 1ns / 1ps

// Each input transaction is one event (encoder sample, mode button, select
// button or sensor tick) and yields exactly one result transaction showing the
// controller state after that event. The event is applied by the next-state
// logic in front of the state register, which also serves as the result
// register, so the result is offered in the cycle after acceptance.
// A new event is accepted every cycle while the result side keeps taking
// results; the input stalls only while a result waits unread.

module fan_menu_mode_controller_unit
    import fmmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fmmc_stream_if.sink   in_ch,
    fmmc_stream_if.source out_ch
);

    fmmc_state_t state_reg;
    fmmc_state_t state_next;
    logic        out_valid_reg;
    logic        in_accept;
    in_item_t    item;

    assign item      = in_item_t'(in_ch.data);
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // event logic
    fmmc_step u_step (
        .item (item),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.menu_open        <= 1'b0;
            state_reg.cursor           <= CURSOR_BACK;
            state_reg.manual_flag_mode <= 1'b0;
            state_reg.fan_on_flag      <= 1'b0;
            state_reg.prev_clk         <= 1'b1;
            state_reg.duty             <= DUTY_OFF;
            out_valid_reg              <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result transaction
    always_comb
    begin
        out_ch.valid              = out_valid_reg;
        out_ch.data               = '0;
        out_ch.data.duty_percent  = state_reg.duty;
        out_ch.data.in_menu       = state_reg.menu_open;
        out_ch.data.cursor_pos    = state_reg.cursor;
        out_ch.data.manual_mode   = state_reg.manual_flag_mode;
        out_ch.data.manual_fan_on = state_reg.fan_on_flag;
    end

    // checks
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted event produced no result");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg))
        else $error("state changed without an event");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cursor != 2'd3)
        else $error("cursor out of range");

    a_duty_levels: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.duty == DUTY_OFF || state_reg.duty == DUTY_LOW
        || state_reg.duty == DUTY_MID || state_reg.duty == DUTY_FULL)
        else $error("duty not a legal level");

    a_menu_blocks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && state_reg.menu_open && item.opcode == OP_MODE)
        |=> $stable(state_reg))
        else $error("mode button acted inside the menu");

endmodule

// ----- tb/sv/tb.sv -----
// testbench: random and directed event stream for the fan menu and mode controller
`timescale 1ns / 1ps

module tb;
    import fmmc_pkg::*;

    // tracks the controller state and the results still owed by the block
    class fan_state_tracker;
        fmmc_state_t st;
        out_item_t   owed[$];
        int          errors;

        function new();
            st.menu_open        = 1'b0;
            st.cursor           = CURSOR_BACK;
            st.manual_flag_mode = 1'b0;
            st.fan_on_flag      = 1'b0;
            st.prev_clk         = 1'b1;
            st.duty             = DUTY_OFF;
            errors              = 0;
        endfunction

        // tiered duty from the three readings, highest tier wins
        function logic [6:0] tier_duty(logic [7:0] t, logic [7:0] h, logic [11:0] g);
            if (t > TEMP_FULL || h > HUM_FULL || g > GAS_FULL)
                return DUTY_FULL;
            if (t > TEMP_MID || h > HUM_MID || g > GAS_MID)
                return DUTY_MID;
            if (t > TEMP_LOW || h > HUM_LOW || g > GAS_LOW)
                return DUTY_LOW;
            return DUTY_OFF;
        endfunction

        // apply one accepted event and queue the state that should follow
        function void note_event(in_item_t ev);
            out_item_t want;
            case (ev.opcode)
                OP_ENCODER:
                begin
                    if (!ev.clk_level && st.prev_clk && st.menu_open)
                    begin
                        if (ev.dt_level)
                            st.cursor = (st.cursor == CURSOR_BACK) ? CURSOR_LAST
                                                                   : st.cursor - 2'd1;
                        else
                            st.cursor = (st.cursor >= CURSOR_LAST) ? CURSOR_BACK
                                                                   : st.cursor + 2'd1;
                    end
                    st.prev_clk = ev.clk_level;
                end
                OP_MODE:
                begin
                    if (!st.menu_open)
                    begin
                        if (!st.manual_flag_mode)
                        begin
                            st.manual_flag_mode = 1'b1;
                            st.fan_on_flag      = 1'b0;
                        end
                        else
                            st.manual_flag_mode = 1'b0;
                    end
                end
                OP_SELECT:
                begin
                    if (!st.menu_open)
                    begin
                        st.menu_open = 1'b1;
                        st.cursor    = CURSOR_BACK;
                    end
                    else
                    begin
                        if (st.cursor == CURSOR_FAN_OFF)
                        begin
                            st.manual_flag_mode = 1'b1;
                            st.fan_on_flag      = 1'b0;
                            st.duty             = DUTY_OFF;
                        end
                        else if (st.cursor == CURSOR_FAN_ON)
                        begin
                            st.manual_flag_mode = 1'b1;
                            st.fan_on_flag      = 1'b1;
                            st.duty             = DUTY_FULL;
                        end
                        st.menu_open = 1'b0;
                    end
                end
                default:
                begin
                    if (!st.menu_open && !st.manual_flag_mode)
                        st.duty = tier_duty(ev.temperature, ev.humidity, ev.gas_level);
                end
            endcase
            want.duty_percent  = st.duty;
            want.in_menu       = st.menu_open;
            want.cursor_pos    = st.cursor;
            want.manual_mode   = st.manual_flag_mode;
            want.manual_fan_on = st.fan_on_flag;
            owed.push_back(want);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // compare one result transaction with the oldest owed state
        task check_result(out_item_t got);
            out_item_t want;
            if (owed.size() == 0)
            begin
                report("result transaction with nothing owed");
                return;
            end
            want = owed.pop_front();
            if (got.duty_percent !== want.duty_percent)
                report($sformatf("duty_percent %0d, want %0d",
                                 got.duty_percent, want.duty_percent));
            if (got.in_menu !== want.in_menu)
                report($sformatf("in_menu %0b, want %0b", got.in_menu, want.in_menu));
            if (got.cursor_pos !== want.cursor_pos)
                report($sformatf("cursor_pos %0d, want %0d",
                                 got.cursor_pos, want.cursor_pos));
            if (got.manual_mode !== want.manual_mode)
                report($sformatf("manual_mode %0b, want %0b",
                                 got.manual_mode, want.manual_mode));
            if (got.manual_fan_on !== want.manual_fan_on)
                report($sformatf("manual_fan_on %0b, want %0b",
                                 got.manual_fan_on, want.manual_fan_on));
        endtask
    endclass

    localparam int EVENT_COUNT = 1700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 200;

    logic clk;
    logic rst_n;
    int   events_sent;
    int   cycles;
    bit   tx_calm;
    bit   hold_long;

    fan_state_tracker tracker = new();

    fmmc_stream_if #(.payload_t(in_item_t))  event_ch ();
    fmmc_stream_if #(.payload_t(out_item_t)) result_ch ();

    fan_menu_mode_controller_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (event_ch),
        .out_ch (result_ch)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("fan_menu_mode_controller_unit test failed");
                $finish;
            end
        end
    end

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // event of the given kind with random content in every field
    function automatic in_item_t make_event(logic [1:0] op);
        in_item_t ev;
        ev.opcode      = op;
        ev.clk_level   = 1'($urandom_range(0, 1));
        ev.dt_level    = 1'($urandom_range(0, 1));
        ev.temperature = 8'($urandom_range(0, 255));
        ev.humidity    = 8'($urandom_range(0, 255));
        ev.gas_level   = 12'($urandom_range(0, 4095));
        return ev;
    endfunction

    // offer one event and wait for it to be taken
    task send_event(input in_item_t ev);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            event_ch.valid <= 1'b0;
        end
        @(negedge clk);
        event_ch.valid <= 1'b1;
        event_ch.data  <= ev;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        tracker.note_event(ev);
        events_sent++;
    endtask

    task send_encoder(input logic c, input logic d);
        in_item_t ev;
        ev           = make_event(OP_ENCODER);
        ev.clk_level = c;
        ev.dt_level  = d;
        send_event(ev);
    endtask

    task send_sensor(input logic [7:0] t, input logic [7:0] h, input logic [11:0] g);
        in_item_t ev;
        ev             = make_event(OP_SENSOR);
        ev.temperature = t;
        ev.humidity    = h;
        ev.gas_level   = g;
        send_event(ev);
    endtask

    task send_button(input logic [1:0] op);
        send_event(make_event(op));
    endtask

    // readings clustered around the thresholds, sometimes anywhere
    function automatic logic [7:0] pick_temp();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(26, 38));
    endfunction

    function automatic logic [7:0] pick_humidity();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(40, 84));
    endfunction

    function automatic logic [11:0] pick_gas();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(1000, 2700));
    endfunction

    // stimulus
    initial
    begin
        int pick;
        int n;
        rst_n          = 1'b0;
        event_ch.valid = 1'b0;
        event_ch.data  = '0;
        events_sent    = 0;
        tx_calm        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tier edges from reset in auto mode
        send_sensor(8'd0, 8'd0, 12'd0);
        send_sensor(8'd255, 8'd255, 12'd4095);
        send_sensor(8'd35, 8'd0, 12'd0);
        send_sensor(8'd0, 8'd80, 12'd0);
        send_sensor(8'd0, 8'd0, 12'd1800);
        send_sensor(8'd30, 8'd60, 12'd1500);
        send_sensor(8'd0, 8'd0, 12'd2501);
        // falling edge on the dashboard leaves the cursor alone
        send_encoder(1'b0, 1'b1);
        send_encoder(1'b1, 1'b0);
        // open menu, buttons and ticks inside are ignored
        send_button(OP_SELECT);
        send_button(OP_MODE);
        send_sensor(8'd255, 8'd255, 12'd4095);
        // down from the first entry wraps to the last
        send_encoder(1'b0, 1'b1);
        // low level held is no edge
        send_encoder(1'b0, 1'b0);
        send_encoder(1'b1, 1'b1);
        // up from the last entry wraps to the first
        send_encoder(1'b0, 1'b0);
        send_encoder(1'b1, 1'b0);
        send_encoder(1'b0, 1'b0);
        // fan off entry forces manual, then ticks do nothing
        send_button(OP_SELECT);
        send_sensor(8'd255, 8'd255, 12'd4095);
        // fan on entry, then back to auto and into manual again clears the flag
        send_button(OP_SELECT);
        send_encoder(1'b1, 1'b1);
        send_encoder(1'b0, 1'b1);
        send_button(OP_SELECT);
        send_button(OP_MODE);
        send_button(OP_MODE);
        // back entry just closes the menu
        send_button(OP_SELECT);
        send_button(OP_SELECT);

        // random part
        while (events_sent < EVENT_COUNT)
        begin
            if ($urandom_range(0, 15) == 0)
                tx_calm = !tx_calm;
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // menu trip: open, turn a few detents, pick an entry
                send_button(OP_SELECT);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_button(OP_ENCODER);
                    else
                    begin
                        send_encoder(1'b1, 1'($urandom_range(0, 1)));
                        send_encoder(1'b0, 1'($urandom_range(0, 1)));
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    send_button($urandom_range(0, 1) ? OP_MODE : OP_SENSOR);
                send_button(OP_SELECT);
            end
            else if (pick < 65)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_sensor(pick_temp(), pick_humidity(), pick_gas());
            end
            else if (pick < 80)
                send_button(OP_MODE);
            else
                send_button(2'($urandom_range(0, 3)));
        end
        @(negedge clk);
        event_ch.valid <= 1'b0;

        // drain
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.errors == 0)
            $display("fan_menu_mode_controller_unit test passed");
        else
            $display("fan_menu_mode_controller_unit test failed");
        $finish;
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin
        hold_long = 1'b0;
        wait (events_sent >= 400);
        @(posedge clk);
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
    end

    // result receiver with random stalls
    initial
    begin
        int  stall_left;
        int  r;
        bit  rx_calm;
        bit  take;
        result_ch.ready = 1'b0;
        stall_left      = 0;
        rx_calm         = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            if (hold_long)
                take = 1'b0;
            else if (stall_left > 0)
            begin
                take = 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (rx_calm || r < 70)
                    take = 1'b1;
                else if (r < 95)
                begin
                    take       = 1'b0;
                    stall_left = $urandom_range(0, 3);
                end
                else
                begin
                    take       = 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
            result_ch.ready <= take;
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                tracker.check_result(result_ch.data);
        end
    end

endmodule
